// ===== sv/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg: shared constants for the sorted table binary search unit
// Field widths, request action codes and configuration register addresses.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Default table depth
  localparam int unsigned TableDepthDefault = 256;

  // Payload field widths
  localparam int unsigned IndexW = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 9;

  // Request action codes
  localparam logic ActWrite  = 1'b0;
  localparam logic ActSearch = 1'b1;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegEntriesInUse = 3'd0;

endpackage

// ===== sv/stbs_if.sv =====
// ----------------------------------------------------------------------------
// stbs_req_if / stbs_rsp_if: request and result channels
// Valid/ready channels carrying table writes, search keys and search results.
// ----------------------------------------------------------------------------
interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [stbs_pkg::IndexW-1:0]         entry_index;
  logic signed [stbs_pkg::ValueW-1:0]  value;

  modport source (output valid, action, entry_index, value, input ready);
  modport sink   (input valid, action, entry_index, value, output ready);
endinterface

interface stbs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [stbs_pkg::IndexW-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// ===== sv/sorted_table_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit: halving search over a sorted RAM table
// Stores signed 32-bit entries by index and looks up keys with a binary
// search over the first entries_in_use entries (at most TABLE_DEPTH), one RAM probe per cycle.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  req_i     in    valid/ready    action, entry_index, value
//  rsp_o     out   valid/ready    found, position
//  apb       in    psel/penable   paddr, pwdata, pwrite -> prdata, pready
//
// A search makes P table probes (at most floor(log2(n)) + 1, so 9 for 256
// entries); the probe loop is paced by the registered read port of the
// table RAM. An empty search range skips the probes and goes straight to
// the result.
// Reset clears the control state and entries_in_use; table contents stay
// undefined until written. A stalled result waits in the output register
// while the next request is taken; a second result waits in the search unit.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  stbs_req_if.sink                      req_i,
  stbs_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stbs_pkg::ApbAddrW-1:0] paddr,
  input  logic [stbs_pkg::ApbDataW-1:0] pwdata,
  output logic [stbs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountMax = (1 << stbs_pkg::CountW) - 1;
  localparam int unsigned BoundMax = (TABLE_DEPTH > CountMax) ? TABLE_DEPTH : CountMax;
  localparam int unsigned CW = $clog2(BoundMax + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [stbs_pkg::CountW-1:0]       count_q;
  logic [CW-1:0]                     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]                     n_sat;
  logic [CW:0]                       mid_sum;
  logic signed [stbs_pkg::ValueW-1:0] key_q, key_d;
  logic signed [stbs_pkg::ValueW-1:0] rd_data_q;
  logic signed [stbs_pkg::ValueW-1:0] table_mem [TABLE_DEPTH];
  logic [AW-1:0]                     rd_addr, wr_addr;
  logic                              wr_en;
  logic                              req_fire, slot_free;
  logic                              res_found_q, res_found_d;
  logic [stbs_pkg::IndexW-1:0]       res_pos_q, res_pos_d;
  logic                              out_valid_q;
  logic                              out_found_q;
  logic [stbs_pkg::IndexW-1:0]       out_pos_q;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == stbs_pkg::RegEntriesInUse) ? stbs_pkg::ApbDataW'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == stbs_pkg::RegEntriesInUse)) begin
      count_q <= pwdata[stbs_pkg::CountW-1:0];
    end
  end

  // Saturate the search range at the table depth
  assign n_sat = (CW'(count_q) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  // Table write port
  assign wr_en   = req_fire && (req_i.action == stbs_pkg::ActWrite) &&
                   (32'(req_i.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(req_i.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= req_i.value;
    end
  end

  // Table read port, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= table_mem[rd_addr];
  end

  // Start a search, narrow the range per probe and wait for a free output slot
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    unique case (state_q)
      S_IDLE: begin
        lo_d  = '0;
        hi_d  = n_sat;
        key_d = req_i.value;
        if (req_fire && (req_i.action == stbs_pkg::ActSearch)) begin
          if (n_sat == '0) begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = S_WAIT;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (rd_data_q == key_q) begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q[stbs_pkg::IndexW-1:0];
          state_d     = S_WAIT;
        end else begin
          if (key_q < rd_data_q) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q + CW'(1);
          end
          if (lo_d >= hi_d) begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Floor midpoint of the inclusive range [lo, hi-1]
  assign mid_sum = {1'b0, lo_d} + {1'b0, hi_d} - (CW+1)'(1);
  assign mid_d   = mid_sum[CW:1];
  assign rd_addr = mid_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_WAIT) && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_WAIT) && slot_free) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.position = out_pos_q;

  // Checks
  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q < hi_q))
    else $error("probe with empty search range");

  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (mid_q < n_sat))
    else $error("probe outside the searched entries");

  a_miss_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |-> (rsp_o.position == '0))
    else $error("miss result with nonzero position");

  a_empty_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.action == stbs_pkg::ActSearch) && (n_sat == '0))
      |=> (state_q == S_WAIT) && !res_found_q)
    else $error("empty table search did not answer at once");

endmodule
